// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the extent map overlap table.
// Needs clk and rst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/emot_pkg.sv =====
`default_nettype none
// Package of the extent map overlap table: sizes, operation and result codes,
// controller state type, extent and result records. No dependencies.
package emot_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = 48;
    localparam int POS_W  = 4;

    localparam int IN_TDATA_W  = 152;   // 148 field bits, zero filled to bytes
    localparam int OUT_TDATA_W = 208;   // 206 field bits, zero filled to bytes

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ADDR_W-1:0] addr_t;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_OVERLAP = 2'd2,
        OP_QUERY   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY_POS = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CLS_NONE       = 2'd0,
        CLS_COVERED    = 2'd1,
        CLS_COVERS_ALL = 2'd2,
        CLS_PARTIAL    = 2'd3
    } class_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_EMIT_RD,
        S_EMIT_CHK,
        S_FINAL
    } state_t;

    // one stored extent as held in the memory
    typedef struct packed {
        addr_t local_off;
        addr_t length;
        addr_t offset;
    } extent_t;

    // one result transfer
    typedef struct packed {
        addr_t   translated_offset;
        logic    found;
        addr_t   entry_local;
        addr_t   entry_count;
        addr_t   entry_offset;
        logic [POS_W-1:0] entry_position;
        cnt_t    overlap_count;
        class_t  class_code;
        status_t status;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/extent_map_overlap_table_unit.sv =====
`default_nettype none
// Top level of the extent map overlap table: controller, position map,
// extent memory and output register. Uses emot_pkg and assert_macros.svh.

// Ordered table of up to 16 extents (offset, length, local offset), head at
// position 0. Extents sit in a 16-entry synchronous memory at fixed physical
// slots; a register map from table position to slot makes insert at the head
// and delete with gap closing a single update of the map. Overlap and query
// walk the table through the single memory read port, one read and one check
// per stored extent: query stops at the first covering extent, overlap makes a
// counting pass over all used entries and then an emitting pass up to the
// last match. One result register sits on the output side; a new item is
// taken only while the controller is idle, and results stall on m_axis_tready
// without loss. No clearing pass is needed after reset.
`include "assert_macros.svh"

module extent_map_overlap_table_unit
    import emot_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // req_offset[47:0], req_count[95:48], req_local[143:96], position[147:144]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // status[1:0], class_code[3:2], overlap_count[8:4], entry_position[12:9],
    // entry_offset[60:13], entry_count[108:61], entry_local[156:109],
    // found[157], translated_offset[205:158]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tlast
);

    state_t state_reg, state_next;

    // request held for the whole item
    op_t              req_op_reg;
    addr_t            req_off_reg, req_cnt_reg, req_local_reg;
    logic [POS_W-1:0] req_pos_reg;

    // position to physical slot map, positions >= used_reg hold free slots
    idx_t map_reg  [DEPTH];
    idx_t map_next [DEPTH];
    cnt_t used_reg, used_next;

    idx_t idx_reg, idx_next;
    cnt_t hits_reg, hits_next;
    cnt_t emit_reg, emit_next;
    logic first_cov_reg, first_cov_next;
    logic all_in_reg, all_in_next;
    logic found_reg, found_next;
    addr_t cov_off_reg, cov_off_next;
    addr_t cov_local_reg, cov_local_next;

    // extent memory
    extent_t mem [DEPTH];
    extent_t rd_reg;
    logic    mem_we, mem_re;
    idx_t    mem_wa, mem_ra;
    extent_t mem_wd;

    // output register
    logic    out_valid_reg;
    result_t out_res_reg, res;
    logic    out_last_reg, res_last;
    logic    out_load, out_free;

    logic in_fire;

    // compare unit on the extent read back
    logic [ADDR_W:0] e_end, r_end;
    logic ovl, ent_in_req, req_in_ent;
    logic last_idx;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    assign e_end = {1'b0, rd_reg.offset} + {1'b0, rd_reg.length};
    assign r_end = {1'b0, req_off_reg} + {1'b0, req_cnt_reg};

    assign ovl = ((rd_reg.offset <= req_off_reg) && (e_end > {1'b0, req_off_reg}))
              || ((req_off_reg <= rd_reg.offset) && (r_end > {1'b0, rd_reg.offset}));
    assign ent_in_req = (req_off_reg <= rd_reg.offset) && (r_end >= e_end);
    assign req_in_ent = (rd_reg.offset <= req_off_reg) && (e_end >= r_end);

    assign last_idx = ({1'b0, idx_reg} + cnt_t'(1)) == used_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            idx_reg       <= '0;
            hits_reg      <= '0;
            emit_reg      <= '0;
            first_cov_reg <= 1'b0;
            all_in_reg    <= 1'b1;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
            begin
                map_reg[i] <= idx_t'(i);
            end
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            idx_reg       <= idx_next;
            hits_reg      <= hits_next;
            emit_reg      <= emit_next;
            first_cov_reg <= first_cov_next;
            all_in_reg    <= all_in_next;
            found_reg     <= found_next;
            map_reg       <= map_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_op_reg    <= op_t'(s_axis_tuser);
            req_off_reg   <= s_axis_tdata[47:0];
            req_cnt_reg   <= s_axis_tdata[95:48];
            req_local_reg <= s_axis_tdata[143:96];
            req_pos_reg   <= s_axis_tdata[147:144];
        end
        cov_off_reg   <= cov_off_next;
        cov_local_reg <= cov_local_next;
        if (out_load)
        begin
            out_res_reg  <= res;
            out_last_reg <= res_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_ra];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        map_next       = map_reg;
        idx_next       = idx_reg;
        hits_next      = hits_reg;
        emit_next      = emit_reg;
        first_cov_next = first_cov_reg;
        all_in_next    = all_in_reg;
        found_next     = found_reg;
        cov_off_next   = cov_off_reg;
        cov_local_next = cov_local_reg;
        s_axis_tready  = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = map_reg[used_reg[IDX_W-1:0]];
        mem_wd         = '{local_off: req_local_reg, length: req_cnt_reg,
                           offset: req_off_reg};
        mem_re         = 1'b0;
        mem_ra         = map_reg[idx_reg];
        out_load       = 1'b0;
        res            = '0;
        res_last       = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                idx_next       = '0;
                hits_next      = '0;
                emit_next      = '0;
                first_cov_next = 1'b0;
                all_in_next    = 1'b1;
                found_next     = 1'b0;
                unique case (req_op_reg)
                    OP_INSERT:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                            if (used_reg == cnt_t'(DEPTH))
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                mem_we      = 1'b1;
                                used_next   = used_reg + cnt_t'(1);
                                map_next[0] = map_reg[used_reg[IDX_W-1:0]];
                                for (int i = 1; i < DEPTH; i++)
                                begin
                                    if (cnt_t'(i) <= used_reg)
                                    begin
                                        map_next[i] = map_reg[i-1];
                                    end
                                end
                            end
                        end
                    end
                    OP_DELETE:
                    begin
                        if (out_free)
                        begin
                            out_load   = 1'b1;
                            state_next = S_IDLE;
                            if (cnt_t'(req_pos_reg) >= used_reg)
                            begin
                                res.status = ST_EMPTY_POS;
                            end
                            else
                            begin
                                used_next = used_reg - cnt_t'(1);
                                for (int i = 0; i < DEPTH; i++)
                                begin
                                    // deleted slot parks just past the new end
                                    if (cnt_t'(i + 1) == used_reg)
                                    begin
                                        map_next[i] = map_reg[req_pos_reg];
                                    end
                                    else if ((cnt_t'(i) >= cnt_t'(req_pos_reg))
                                             && (cnt_t'(i + 1) < used_reg))
                                    begin
                                        map_next[i] = map_reg[(i + 1) % DEPTH];
                                    end
                                end
                            end
                        end
                    end
                    OP_OVERLAP, OP_QUERY:
                    begin
                        if (used_reg == '0)
                        begin
                            state_next = S_FINAL;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                endcase
            end

            S_SCAN_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK:
            begin
                if (req_op_reg == OP_QUERY)
                begin
                    if (req_in_ent)
                    begin
                        found_next     = 1'b1;
                        cov_off_next   = rd_reg.offset;
                        cov_local_next = rd_reg.local_off;
                        state_next     = S_FINAL;
                    end
                    else if (last_idx)
                    begin
                        state_next = S_FINAL;
                    end
                    else
                    begin
                        idx_next   = idx_reg + idx_t'(1);
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    if (ovl)
                    begin
                        hits_next = hits_reg + cnt_t'(1);
                        if (hits_reg == '0)
                        begin
                            first_cov_next = req_in_ent;
                        end
                        if (!ent_in_req)
                        begin
                            all_in_next = 1'b0;
                        end
                    end
                    if (last_idx)
                    begin
                        idx_next = '0;
                        if (hits_next == '0)
                        begin
                            state_next = S_FINAL;
                        end
                        else
                        begin
                            state_next = S_EMIT_RD;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + idx_t'(1);
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_EMIT_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_EMIT_CHK;
            end

            S_EMIT_CHK:
            begin
                // read data holds while the output stalls
                if (!ovl)
                begin
                    idx_next   = idx_reg + idx_t'(1);
                    state_next = S_EMIT_RD;
                end
                else if (out_free)
                begin
                    out_load = 1'b1;
                    priority if ((hits_reg == cnt_t'(1)) && first_cov_reg)
                    begin
                        res.class_code = CLS_COVERED;
                    end
                    else if (all_in_reg)
                    begin
                        res.class_code = CLS_COVERS_ALL;
                    end
                    else
                    begin
                        res.class_code = CLS_PARTIAL;
                    end
                    res.overlap_count  = hits_reg;
                    res.entry_position = POS_W'(idx_reg);
                    res.entry_offset   = rd_reg.offset;
                    res.entry_count    = rd_reg.length;
                    res.entry_local    = rd_reg.local_off;
                    res_last           = (emit_reg + cnt_t'(1)) == hits_reg;
                    emit_next          = emit_reg + cnt_t'(1);
                    if (res_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + idx_t'(1);
                        state_next = S_EMIT_RD;
                    end
                end
            end

            S_FINAL:
            begin
                if (out_free)
                begin
                    out_load  = 1'b1;
                    res.found = found_reg;
                    if (found_reg)
                    begin
                        res.translated_offset = cov_local_reg + (req_off_reg - cov_off_reg);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'b00, out_res_reg};

    `ASSERT_IMPLIES(a_used_bound, 1'b1, used_reg <= cnt_t'(DEPTH))
    `ASSERT_NEXT(a_insert_grows,
        (state_reg == S_EXEC) && (req_op_reg == OP_INSERT) && out_free
            && (used_reg != cnt_t'(DEPTH)),
        used_reg == $past(used_reg) + cnt_t'(1))
    `ASSERT_IMPLIES(a_emit_bound, state_reg == S_EMIT_CHK,
        (emit_reg < hits_reg) && (hits_reg <= used_reg))

endmodule

`default_nettype wire

// ===== tb/tb_extent_map_overlap_table_unit.sv =====
// Testbench of extent_map_overlap_table_unit: random and directed insert, delete,
// overlap and query requests, checked against a table model kept in a scoreboard.
// Depends on emot_pkg and the RTL of the block only.
module tb_extent_map_overlap_table_unit;
    import emot_pkg::*;

    localparam int    LIMIT      = 600000;
    localparam int    ITEM_GOAL  = 440;
    localparam int    SETTLE     = 100;
    localparam addr_t ADDR_MAX   = '1;

    typedef enum {PH_FILL, PH_MIX, PH_DRAIN} phase_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;

    // Table model and store of expected result transfers
    class extent_table_checker;
        addr_t   ext_off[DEPTH];
        addr_t   ext_len[DEPTH];
        addr_t   ext_loc[DEPTH];
        int      used;
        int      fails;
        int      checked;
        result_t want_q[$];
        bit      want_last_q[$];

        function new();
            used    = 0;
            fails   = 0;
            checked = 0;
        endfunction

        function logic [ADDR_W:0] wide_sum(addr_t a, addr_t b);
            return {1'b0, a} + {1'b0, b};
        endfunction

        function bit overlapping(addr_t eo, addr_t el, addr_t ro, addr_t rc);
            return (eo <= ro && wide_sum(eo, el) > {1'b0, ro}) ||
                   (ro <= eo && wide_sum(ro, rc) > {1'b0, eo});
        endfunction

        // inner extent lies fully within outer extent
        function bit contained(addr_t io, addr_t il, addr_t oo, addr_t ol);
            return oo <= io && wide_sum(oo, ol) >= wide_sum(io, il);
        endfunction

        function void push_result(result_t r, bit last);
            want_q.push_back(r);
            want_last_q.push_back(last);
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        function void note_input(op_t op, addr_t ro, addr_t rc, addr_t rl, logic [3:0] pos);
            result_t r;
            int      hits;
            int      first;
            int      n;
            bit      all_in;
            class_t  cls;
            r      = '0;
            hits   = 0;
            first  = 0;
            n      = 0;
            all_in = 1'b1;
            case (op)
                OP_INSERT:
                begin
                    if (used >= DEPTH)
                        r.status = ST_FULL;
                    else
                    begin
                        for (int i = used; i > 0; i--)
                        begin
                            ext_off[i] = ext_off[i-1];
                            ext_len[i] = ext_len[i-1];
                            ext_loc[i] = ext_loc[i-1];
                        end
                        ext_off[0] = ro;
                        ext_len[0] = rc;
                        ext_loc[0] = rl;
                        used++;
                    end
                    push_result(r, 1'b1);
                end
                OP_DELETE:
                begin
                    if (int'(pos) >= used)
                        r.status = ST_EMPTY_POS;
                    else
                    begin
                        for (int i = int'(pos); i + 1 < used; i++)
                        begin
                            ext_off[i] = ext_off[i+1];
                            ext_len[i] = ext_len[i+1];
                            ext_loc[i] = ext_loc[i+1];
                        end
                        used--;
                    end
                    push_result(r, 1'b1);
                end
                OP_QUERY:
                begin
                    for (int i = 0; i < used; i++)
                    begin
                        if (contained(ro, rc, ext_off[i], ext_len[i]))
                        begin
                            r.found             = 1'b1;
                            r.translated_offset = ext_loc[i] + (ro - ext_off[i]);
                            break;
                        end
                    end
                    push_result(r, 1'b1);
                end
                default:
                begin
                    for (int i = 0; i < used; i++)
                    begin
                        if (overlapping(ext_off[i], ext_len[i], ro, rc))
                        begin
                            if (hits == 0)
                                first = i;
                            hits++;
                            if (!contained(ext_off[i], ext_len[i], ro, rc))
                                all_in = 1'b0;
                        end
                    end
                    if (hits == 0)
                        cls = CLS_NONE;
                    else if (hits == 1 && contained(ro, rc, ext_off[first], ext_len[first]))
                        cls = CLS_COVERED;
                    else if (all_in)
                        cls = CLS_COVERS_ALL;
                    else
                        cls = CLS_PARTIAL;
                    if (hits == 0)
                        push_result(r, 1'b1);
                    for (int i = 0; i < used; i++)
                    begin
                        if (overlapping(ext_off[i], ext_len[i], ro, rc))
                        begin
                            n++;
                            r.class_code     = cls;
                            r.overlap_count  = cnt_t'(hits);
                            r.entry_position = 4'(i);
                            r.entry_offset   = ext_off[i];
                            r.entry_count    = ext_len[i];
                            r.entry_local    = ext_loc[i];
                            push_result(r, n == hits);
                        end
                    end
                end
            endcase
        endfunction

        function void compare(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                fails++;
                if (fails <= 10)
                    $display("result %0d: %s expected %0h, got %0h", checked, name, want, got);
            end
        endfunction

        function void check_result(result_t got, logic got_last);
            result_t want;
            bit      want_last;
            checked++;
            if (want_q.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("result %0d arrived with nothing pending", checked);
                return;
            end
            want      = want_q.pop_front();
            want_last = want_last_q.pop_front();
            compare("status", want.status, got.status);
            compare("class_code", want.class_code, got.class_code);
            compare("overlap_count", want.overlap_count, got.overlap_count);
            compare("entry_position", want.entry_position, got.entry_position);
            compare("entry_offset", want.entry_offset, got.entry_offset);
            compare("entry_count", want.entry_count, got.entry_count);
            compare("entry_local", want.entry_local, got.entry_local);
            compare("found", want.found, got.found);
            compare("translated_offset", want.translated_offset, got.translated_offset);
            compare("last", want_last, got_last);
        endfunction

        function int close();
            if (want_q.size() != 0)
            begin
                fails++;
                if (fails <= 10)
                    $display("%0d expected results never arrived", want_q.size());
            end
            return fails;
        endfunction
    endclass

    extent_table_checker table_chk;

    int    cycles     = 0;
    int    accepted   = 0;
    int    burst_left = 0;
    int    rx_mode    = 0;
    int    rx_left    = 0;
    addr_t win_base   = '0;
    int    win_span   = 256;

    extent_map_overlap_table_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: modes of free flow, coin flips, periodic and heavy stalls
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(20, 120);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (cycles % 5) != 0;
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            table_chk.check_result(result_t'(m_axis_tdata[$bits(result_t)-1:0]), m_axis_tlast);
    end

    function automatic addr_t rand_addr();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[ADDR_W-1:0];
    endfunction

    // uniform in [0, lim]
    function automatic addr_t rand_upto(addr_t lim);
        logic [63:0] w;
        logic [63:0] m;
        w = {$urandom(), $urandom()};
        m = {16'h0, lim} + 64'd1;
        w = w % m;
        return w[ADDR_W-1:0];
    endfunction

    function automatic addr_t gen_offset();
        if ($urandom_range(0, 19) == 0)
            return rand_addr();
        return win_base + addr_t'($urandom_range(0, win_span));
    endfunction

    function automatic addr_t gen_len();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return '0;
        if (r == 2)
            return rand_addr();
        if (r == 3)
            return ADDR_MAX;
        return addr_t'($urandom_range(1, win_span / 2 + 1));
    endfunction

    function automatic void pick_window();
        case ($urandom_range(0, 3))
            0:       win_base = '0;
            1:       win_base = ADDR_MAX - 48'd300;
            default: win_base = rand_addr();
        endcase
        win_span = $urandom_range(64, 600);
    endfunction

    function automatic op_t pick_op(phase_t ph);
        int r;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL:
            begin
                if (r < 50) return OP_INSERT;
                if (r < 55) return OP_DELETE;
            end
            PH_MIX:
            begin
                if (r < 30) return OP_INSERT;
                if (r < 50) return OP_DELETE;
            end
            default:
            begin
                if (r < 5)  return OP_INSERT;
                if (r < 55) return OP_DELETE;
            end
        endcase
        return (r < 80) ? OP_OVERLAP : OP_QUERY;
    endfunction

    task automatic send(op_t op, addr_t ro, addr_t rc, addr_t rl, logic [3:0] pos);
        int gap;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'b0, pos, rl, rc, ro};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        table_chk.note_input(op, ro, rc, rl, pos);
        accepted++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (table_chk.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_item(op_t op);
        addr_t      o;
        addr_t      c;
        addr_t      eo;
        addr_t      el;
        addr_t      d;
        logic [3:0] p;
        int         i;
        int         r;
        int         m;
        o = gen_offset();
        c = gen_len();
        p = 4'($urandom_range(0, 15));
        r = $urandom_range(0, 9);
        if (table_chk.used > 0)
        begin
            i  = $urandom_range(0, table_chk.used - 1);
            eo = table_chk.ext_off[i];
            el = table_chk.ext_len[i];
            case (op)
                OP_DELETE:
                begin
                    // mostly the highest position, as software deletes top down
                    if (r < 7)
                        p = 4'(table_chk.used - 1);
                    else if (r < 9)
                        p = 4'(i);
                end
                OP_QUERY:
                begin
                    if (r < 7)
                    begin
                        d = rand_upto(el);
                        o = eo + d;
                        c = rand_upto(el - d);
                    end
                end
                OP_OVERLAP:
                begin
                    if (r < 4)
                    begin
                        d = rand_upto(el);
                        o = eo + d;
                        c = rand_upto(el - d);
                    end
                    else if (r < 7)
                    begin
                        // widen around a stored extent to reach the covers-all class
                        m = $urandom_range(0, 8);
                        o = eo - addr_t'(m);
                        c = el + addr_t'(2 * m);
                    end
                end
                default:
                begin
                end
            endcase
        end
        send(op, o, c, rand_addr(), p);
    endtask

    initial
    begin
        phase_t ph;
        table_chk     = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_INSERT;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // empty table
        send(OP_DELETE, '0, '0, '0, 4'd0);
        send(OP_OVERLAP, '0, ADDR_MAX, '0, 4'd0);
        send(OP_QUERY, '0, '0, '0, 4'd0);
        // table after these: (120,10) (0,0) (max,max) (100,50)
        send(OP_INSERT, 48'd100, 48'd50, 48'd1000, 4'd0);
        send(OP_INSERT, ADDR_MAX, ADDR_MAX, ADDR_MAX, 4'd0);
        send(OP_INSERT, '0, '0, '0, 4'd0);
        send(OP_INSERT, 48'd120, 48'd10, 48'd5, 4'd0);
        send(OP_OVERLAP, 48'd110, 48'd5, '0, 4'd0);
        send(OP_OVERLAP, 48'd90, 48'd100, '0, 4'd0);
        send(OP_OVERLAP, 48'd140, 48'd20, '0, 4'd0);
        send(OP_OVERLAP, '0, '0, '0, 4'd0);
        // end sums past the top of the address space
        send(OP_OVERLAP, ADDR_MAX - 48'd1, 48'd5, '0, 4'd0);
        send(OP_OVERLAP, '0, ADDR_MAX, '0, 4'd0);
        send(OP_QUERY, ADDR_MAX, 48'd3, '0, 4'd0);
        send(OP_QUERY, 48'd110, 48'd10, '0, 4'd0);
        send(OP_QUERY, 48'd145, 48'd10, '0, 4'd0);
        send(OP_QUERY, '0, '0, '0, 4'd0);
        send(OP_DELETE, '0, '0, '0, 4'd15);
        send(OP_DELETE, '0, '0, '0, 4'd3);
        send(OP_DELETE, '0, '0, '0, 4'd0);
        send(OP_OVERLAP, '0, ADDR_MAX, '0, 4'd0);
        send(OP_INSERT, ADDR_MAX, '0, ADDR_MAX, 4'hf);
        send(OP_QUERY, ADDR_MAX, '0, ADDR_MAX, 4'hf);
        drain_results();

        while (accepted < ITEM_GOAL)
        begin
            ph = phase_t'($urandom_range(0, 2));
            pick_window();
            case (ph)
                PH_FILL:
                begin
                    while (table_chk.used < DEPTH)
                        random_item(pick_op(PH_FILL));
                    repeat ($urandom_range(1, 3)) random_item(OP_INSERT);
                    repeat ($urandom_range(2, 6)) random_item(OP_OVERLAP);
                    repeat ($urandom_range(1, 3)) random_item(OP_QUERY);
                end
                PH_MIX:
                begin
                    repeat ($urandom_range(15, 40)) random_item(pick_op(PH_MIX));
                end
                default:
                begin
                    while (table_chk.used > 0)
                        random_item(pick_op(PH_DRAIN));
                    random_item(OP_DELETE);
                end
            endcase
            if ($urandom_range(0, 2) == 0)
                drain_results();
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);
        if (table_chk.close() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
